// File: sv/depth_to_color_pixel_registration_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef DEPTH_TO_COLOR_PIXEL_REGISTRATION_UNIT_MACROS_SVH
`define DEPTH_TO_COLOR_PIXEL_REGISTRATION_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define D2C_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("d2c assertion failed");

// next-cycle implication, disabled in reset
`define D2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("d2c assertion failed");

`endif

// File: sv/d2c_pkg.sv
// Package: shared types and constants of the depth-to-color registration unit.
package d2c_pkg;

  // projection coefficients, R row-major (r[0]=R00 .. r[8]=R22), t[0..2]=T
  typedef struct packed {
    logic [2:0][31:0] t;
    logic [8:0][31:0] r;
  } coef_t;

  typedef enum logic [2:0] {
    REG_R00_R01 = 3'd0,
    REG_R02_R10 = 3'd1,
    REG_R11_R12 = 3'd2,
    REG_R20_R21 = 3'd3,
    REG_R22_T0  = 3'd4,
    REG_T1_T2   = 3'd5,
    REG_FRAME_W = 3'd6,
    REG_FRAME_H = 3'd7
  } reg_idx_t;

  localparam int DEPTH_SHIFT    = 4;
  localparam int DEPTH_W        = 12;
  localparam int ZDEN_THRESHOLD = 16;
  localparam int T_SHIFT        = 16;

endpackage

// File: sv/depth_to_color_pixel_registration_unit.sv
// Top level: configuration registers, front end, queue and back end.
// Takes one depth word per clock while the queue is not full and delivers at most one
// destination write per word, in input order. After the queue, a word passes through
// multiply, row sum, depth scaling with translation, the divider operands, a range
// check, one restoring divider stage per quotient bit and the output register. The
// pipeline advances while the output register is empty or taken; while a result waits,
// the four-word queue ahead of the pipeline takes up to four more words before s_tready
// drops. Coefficients and frame size are read live; the user must see that they are
// written only while the unit is idle, as the unit itself does not enforce this.
module depth_to_color_pixel_registration_unit import d2c_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // depth_raw[15:0]
  input  logic        s_tuser,    // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // dest_x[9:0], dest_y[19:10], depth_value[31:20]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int HEW = $clog2(MAX_HEIGHT + 1);
  localparam int QB  = (CW > RW) ? CW : RW;
  localparam int QW  = DEPTH_W + CW + RW;
  localparam int FWW = WEW + 11;
  localparam int FHW = HEW + 11;

  logic [63:0] coef_r00_r01, coef_r02_r10, coef_r11_r12;
  logic [63:0] coef_r20_r21, coef_r22_t0, coef_t1_t2;
  logic [10:0] frame_width, frame_height;
  logic        wr;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_r00_r01 <= '0;
      coef_r02_r10 <= '0;
      coef_r11_r12 <= '0;
      coef_r20_r21 <= '0;
      coef_r22_t0  <= '0;
      coef_t1_t2   <= '0;
      frame_width  <= 11'd640;
      frame_height <= 11'd360;
    end else if (wr) begin
      case (idx)
        REG_R00_R01: coef_r00_r01 <= pwdata;
        REG_R02_R10: coef_r02_r10 <= pwdata;
        REG_R11_R12: coef_r11_r12 <= pwdata;
        REG_R20_R21: coef_r20_r21 <= pwdata;
        REG_R22_T0:  coef_r22_t0  <= pwdata;
        REG_T1_T2:   coef_t1_t2   <= pwdata;
        REG_FRAME_W: frame_width  <= pwdata[10:0];
        REG_FRAME_H: frame_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_R00_R01: prdata = coef_r00_r01;
      REG_R02_R10: prdata = coef_r02_r10;
      REG_R11_R12: prdata = coef_r11_r12;
      REG_R20_R21: prdata = coef_r20_r21;
      REG_R22_T0:  prdata = coef_r22_t0;
      REG_T1_T2:   prdata = coef_t1_t2;
      REG_FRAME_W: prdata = {53'd0, frame_width};
      REG_FRAME_H: prdata = {53'd0, frame_height};
      default:     prdata = '0;
    endcase
  end

  coef_t coef;
  always_comb begin
    coef.r[0] = coef_r00_r01[63:32];
    coef.r[1] = coef_r00_r01[31:0];
    coef.r[2] = coef_r02_r10[63:32];
    coef.r[3] = coef_r02_r10[31:0];
    coef.r[4] = coef_r11_r12[63:32];
    coef.r[5] = coef_r11_r12[31:0];
    coef.r[6] = coef_r20_r21[63:32];
    coef.r[7] = coef_r20_r21[31:0];
    coef.r[8] = coef_r22_t0[63:32];
    coef.t[0] = coef_r22_t0[31:0];
    coef.t[1] = coef_t1_t2[63:32];
    coef.t[2] = coef_t1_t2[31:0];
  end

  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  assign w_eff = (FWW'(frame_width) > FWW'(MAX_WIDTH))  ? WEW'(MAX_WIDTH)  : WEW'(frame_width);
  assign h_eff = (FHW'(frame_height) > FHW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : HEW'(frame_height);

  logic          q_push, q_pop, q_full, q_not_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  d2c_front #(.CW(CW), .RW(RW), .WEW(WEW), .HEW(HEW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  d2c_fifo #(.W(QW), .AW(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  d2c_back #(.CW(CW), .RW(RW), .WEW(WEW), .HEW(HEW), .QB(QB)) u_back (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .in_valid (q_not_empty),
    .in_data  (q_rdata),
    .in_pop   (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: sv/d2c_front.sv
// Front end: accepts depth words, tracks raster position, pushes work items.
module d2c_front import d2c_pkg::*; #(
  parameter int CW  = 10,
  parameter int RW  = 10,
  parameter int WEW = 11,
  parameter int HEW = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [15:0]               s_tdata,   // depth_raw[15:0]
  input  logic                      s_tuser,   // frame_start
  input  logic [WEW-1:0]            w_eff,
  input  logic [HEW-1:0]            h_eff,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [DEPTH_W+CW+RW-1:0]  q_data
);

  localparam int CCW = CW + WEW;
  localparam int RCW = RW + HEW;

  logic [CW-1:0] column_count, column_count_next, col;
  logic [RW-1:0] row_count, row_count_next, row;
  logic          acc;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;
  assign q_push   = acc;

  assign col = s_tuser ? '0 : column_count;
  assign row = s_tuser ? '0 : row_count;

  assign q_data = {row, col, s_tdata[15:DEPTH_SHIFT]};

  always_comb begin
    column_count_next = col + 1'b1;
    row_count_next    = row;
    if (CCW'(col) + CCW'(1) >= CCW'(w_eff)) begin
      column_count_next = '0;
      if (RCW'(row) + RCW'(1) >= RCW'(h_eff)) begin
        row_count_next = '0;
      end else begin
        row_count_next = row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// File: sv/d2c_fifo.sv
// Small queue between front end and back end.
module d2c_fifo #(
  parameter int W  = 32,
  parameter int AW = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty,
  output logic         full
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign not_empty = count != '0;
  assign full      = count == (AW+1)'(DEPTH);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// File: sv/d2c_back.sv
// Back end: projection pipeline, restoring divider stages, output register.
module d2c_back import d2c_pkg::*; #(
  parameter int CW  = 10,
  parameter int RW  = 10,
  parameter int WEW = 11,
  parameter int HEW = 11,
  parameter int QB  = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  coef_t                     coef,
  input  logic [WEW-1:0]            w_eff,
  input  logic [HEW-1:0]            h_eff,
  input  logic                      in_valid,
  input  logic [DEPTH_W+CW+RW-1:0]  in_data,
  output logic                      in_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata    // dest_x[9:0], dest_y[19:10], depth_value[31:20]
);

  localparam int XW   = (CW > RW) ? CW : RW;
  localparam int PW   = 32 + XW + 1;
  localparam int SW   = PW + 2;
  localparam int PRW  = SW + DEPTH_W + 2;
  localparam int NW   = PRW + 1;
  localparam int RWD  = NW + QB;
  localparam int CMPW = QB + WEW + HEW;

  logic adv;
  assign adv    = !m_tvalid || m_tready;
  assign in_pop = adv && in_valid;

  logic [DEPTH_W-1:0] d0;
  logic [CW-1:0]      col0;
  logic [RW-1:0]      row0;
  assign d0   = in_data[DEPTH_W-1:0];
  assign col0 = in_data[DEPTH_W +: CW];
  assign row0 = in_data[DEPTH_W+CW +: RW];

  // stage 1: coefficient times column and row
  logic                 v1;
  logic [DEPTH_W-1:0]   d1;
  logic signed [PW-1:0] mc [3];
  logic signed [PW-1:0] mr [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1 <= d0;
      for (int i = 0; i < 3; i++) begin
        mc[i] <= $signed(coef.r[3*i])   * $signed({1'b0, col0});
        mr[i] <= $signed(coef.r[3*i+1]) * $signed({1'b0, row0});
      end
    end
  end

  // stage 2: row sums
  logic                 v2;
  logic [DEPTH_W-1:0]   d2;
  logic signed [SW-1:0] sm [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2 <= d1;
      for (int i = 0; i < 3; i++) begin
        sm[i] <= mc[i] + mr[i] + $signed(coef.r[3*i+2]);
      end
    end
  end

  // stage 3: scale by depth, add translation
  logic                  v3;
  logic [DEPTH_W-1:0]    d3;
  logic signed [PRW-1:0] pp [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3 <= d2;
      for (int i = 0; i < 3; i++) begin
        pp[i] <= $signed({1'b0, d2}) * sm[i] + ($signed(coef.t[i]) <<< T_SHIFT);
      end
    end
  end

  // stage 4: magnitudes, signs, denominator threshold check, divider operands
  logic [PRW-1:0] ax, ay, az;
  assign ax = pp[0][PRW-1] ? PRW'(-pp[0]) : PRW'(pp[0]);
  assign ay = pp[1][PRW-1] ? PRW'(-pp[1]) : PRW'(pp[1]);
  assign az = pp[2][PRW-1] ? PRW'(-pp[2]) : PRW'(pp[2]);

  logic               v4, nz4, negx4, negy4;
  logic [DEPTH_W-1:0] d4;
  logic [NW-1:0]      nx4, ny4, dz4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4    <= d3;
      nz4   <= az > PRW'(ZDEN_THRESHOLD);
      negx4 <= pp[0][PRW-1] != pp[2][PRW-1];
      negy4 <= pp[1][PRW-1] != pp[2][PRW-1];
      nx4   <= {ax, 1'b0} + NW'(az);
      ny4   <= {ay, 1'b0} + NW'(az);
      dz4   <= {az, 1'b0};
    end
  end

  // divider: entry stage checks quotient range, then one bit per stage
  logic               dv   [QB+1];
  logic               dnz  [QB+1];
  logic               dngx [QB+1];
  logic               dngy [QB+1];
  logic               dovx [QB+1];
  logic               dovy [QB+1];
  logic [DEPTH_W-1:0] dd   [QB+1];
  logic [NW-1:0]      ddz  [QB+1];
  logic [RWD-1:0]     rx   [QB+1];
  logic [RWD-1:0]     ry   [QB+1];
  logic [QB-1:0]      qx   [QB+1];
  logic [QB-1:0]      qy   [QB+1];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dnz[0]  <= nz4;
      dngx[0] <= negx4;
      dngy[0] <= negy4;
      dovx[0] <= RWD'(nx4) >= (RWD'(dz4) << QB);
      dovy[0] <= RWD'(ny4) >= (RWD'(dz4) << QB);
      dd[0]   <= d4;
      ddz[0]  <= dz4;
      rx[0]   <= RWD'(nx4);
      ry[0]   <= RWD'(ny4);
      qx[0]   <= '0;
      qy[0]   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [RWD-1:0] trial;
    logic           gex, gey;
    assign trial = RWD'(ddz[k]) << B;
    assign gex   = rx[k] >= trial;
    assign gey   = ry[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dnz[k+1]  <= dnz[k];
        dngx[k+1] <= dngx[k];
        dngy[k+1] <= dngy[k];
        dovx[k+1] <= dovx[k];
        dovy[k+1] <= dovy[k];
        dd[k+1]   <= dd[k];
        ddz[k+1]  <= ddz[k];
        rx[k+1]   <= gex ? rx[k] - trial : rx[k];
        ry[k+1]   <= gey ? ry[k] - trial : ry[k];
        qx[k+1]   <= qx[k] | (QB'(gex) << B);
        qy[k+1]   <= qy[k] | (QB'(gey) << B);
      end
    end
  end

  // output register
  logic pass;
  assign pass = dnz[QB] && !dovx[QB] && !dovy[QB]
             && !(dngx[QB] && qx[QB] != '0) && !(dngy[QB] && qy[QB] != '0)
             && (CMPW'(qx[QB]) < CMPW'(w_eff)) && (CMPW'(qy[QB]) < CMPW'(h_eff));

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= dv[QB] && pass;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {dd[QB], 10'(qy[QB]), 10'(qx[QB])};
    end
  end

endmodule

// File: sv/d2c_checker.sv
// Port-level checker for the registration unit, bound to the top level.
`include "depth_to_color_pixel_registration_unit_macros.svh"

module d2c_checker import d2c_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [5:0]  paddr,
  input logic [63:0] pwdata,
  input logic [63:0] prdata,
  input logic        pready
);

  logic width_write, width_read;
  assign width_write = psel && penable && pwrite && paddr == {REG_FRAME_W, 3'b000};
  assign width_read  = psel && !pwrite && paddr == {REG_FRAME_W, 3'b000};

  `D2C_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `D2C_ASSERT_SAME(a_apb_ready, psel && penable, pready)
  `D2C_ASSERT_NEXT(a_width_readback, width_write, !width_read || prdata[10:0] == $past(pwdata[10:0]))

endmodule

bind depth_to_color_pixel_registration_unit d2c_checker u_d2c_checker (.*);
